// ----- design/pme_pkg.sv -----
package pme_pkg;

  localparam int DIR_W = 18;
  localparam int DIR_FRAC = 16;
  localparam int WIDTH_FRAC = 16;

  typedef logic signed [DIR_W-1:0] dir_t;

  typedef struct packed {
    logic [31:0] left_x;
    logic [31:0] left_y;
    logic [31:0] right_x;
    logic [31:0] right_y;
    logic        last_pair;
  } pair_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/pme_divsqrt.sv -----
module pme_divsqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        sqrt_op,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] res
);

  logic [6:0]  cnt;
  logic        busy;
  logic        op;
  logic [63:0] rem;
  logic [63:0] n;
  logic [63:0] d;
  logic [63:0] q;
  logic [63:0] bitv;
  logic [64:0] trial;
  logic [63:0] sq_sum;

  always_comb begin
    trial = {1'b0, rem[62:0], n[63]} - {1'b0, d};
    sq_sum = q + bitv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        op <= sqrt_op;
        rem <= '0;
        n <= num;
        d <= den;
        q <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt <= sqrt_op ? 7'd32 : 7'd64;
      end else if (busy) begin
        if (op) begin
          if (n >= sq_sum) begin
            n <= n - sq_sum;
            q <= (q >> 1) + bitv;
          end else begin
            q <= q >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          n <= n << 1;
          if (!trial[64]) begin
            rem <= trial[63:0];
            q <= {q[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], n[63]};
            q <= {q[62:0], 1'b0};
          end
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = q;

endmodule

// ----- design/polyline_miter_extruder_unit.sv -----
// Polyline miter extruder.
// Input channel: point_x, point_y (signed fixed point) and last_point, taken
// when in_valid is high and in_stall is low. The block holds in_stall high
// while it works on an item and while a result waits.
// Output channel: left_x, left_y, right_x, right_y and last_pair, delivered
// when out_valid is high and out_stall is low. Each point's vertex pair comes
// out when the next point arrives; the last point gives two pairs.
// The configuration channel writes the road width from cfg_data with cfg_valid
// and cfg_ready.
// The first point of a polyline is stored in the idle state unless it is also
// the last. A later point runs normalizing shifts, one square root of 32 steps
// and two divisions of 64 steps for the direction, two more divisions when the
// miter is not clamped, and the offset and emit states. A repeated point skips
// the square root and the direction divisions. For its second pair the last
// point runs the offset and emit states again. One item is in work at a time.
// A receiver stall holds the result register and the sequencer; no item is
// taken until all results of the current one are delivered.
// Reset clears the polyline state and sets the road width to 3277.
module polyline_miter_extruder_unit #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int MITER_CLAMP = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] left_x,
  output logic [31:0] left_y,
  output logic [31:0] right_x,
  output logic [31:0] right_y,
  output logic        last_pair,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_SQ = 4'd2;
  localparam logic [3:0] S_SQW = 4'd3;
  localparam logic [3:0] S_DX = 4'd4;
  localparam logic [3:0] S_DY = 4'd5;
  localparam logic [3:0] S_MQ = 4'd6;
  localparam logic [3:0] S_MX = 4'd7;
  localparam logic [3:0] S_MY = 4'd8;
  localparam logic [3:0] S_OX = 4'd9;
  localparam logic [3:0] S_OY = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;
  localparam logic [3:0] S_WAITD = 4'd13;

  localparam int DIR_FRAC_C = pme_pkg::DIR_FRAC;
  localparam int SH = DIR_FRAC_C + pme_pkg::WIDTH_FRAC + 1 - COORD_FRAC_BITS;
  localparam logic [63:0] LIM = 64'd1 << (2 * DIR_FRAC_C + 1);
  localparam logic [63:0] RND = 64'd1 << (SH - 1);

  logic [3:0]  state;
  logic [3:0]  ret;
  logic [15:0] rw;
  logic [1:0]  seen;
  logic signed [31:0] hx, hy, px, py;
  logic        lastp;
  logic        second;
  pme_pkg::dir_t ix, iy, ox, oy;
  logic signed [34:0] dsx, dsy;
  logic [33:0] ax, ay;
  logic        nx, ny;
  logic [63:0] len;
  logic [63:0] mq;
  logic [35:0] offx, offy;
  logic signed [31:0] ex, ey;
  logic        elast;
  logic        emit_zero;
  pme_pkg::pair_t outr;
  logic        du_start, du_sqrt, du_done;
  logic [63:0] du_num, du_den, du_res;
  logic [63:0] mul;
  logic signed [34:0] sxs, sys;
  logic [33:0] m;
  logic signed [36:0] sofx, sofy;

  pme_divsqrt u_du (
    .clk(clk), .rst(rst), .start(du_start), .sqrt_op(du_sqrt),
    .num(du_num), .den(du_den), .done(du_done), .res(du_res)
  );

  assign in_stall = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;
  assign m = (ax > ay) ? ax : ay;
  assign sxs = 35'(ix) + 35'(ox);
  assign sys = 35'(iy) + 35'(oy);

  always_comb begin
    mul = {30'd0, ax} * {30'd0, ax} + {30'd0, ay} * {30'd0, ay};
    sofx = emit_zero ? 37'sd0 : (nx ? -$signed({1'b0, offx}) : $signed({1'b0, offx}));
    sofy = emit_zero ? 37'sd0 : (ny ? -$signed({1'b0, offy}) : $signed({1'b0, offy}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rw <= 16'd3277;
      seen <= '0;
      out_valid <= 1'b0;
      du_start <= 1'b0;
      hx <= '0; hy <= '0; ix <= '0; iy <= '0;
    end else begin
      du_start <= 1'b0;
      if (cfg_valid) begin
        rw <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            px <= $signed(point_x);
            py <= $signed(point_y);
            lastp <= last_point;
            second <= 1'b0;
            if (seen == 2'd0) begin
              if (last_point) begin
                ex <= $signed(point_x);
                ey <= $signed(point_y);
                elast <= 1'b1;
                emit_zero <= 1'b1;
                state <= S_EMIT;
              end else begin
                hx <= $signed(point_x);
                hy <= $signed(point_y);
                seen <= 2'd1;
              end
            end else begin
              dsx <= 35'($signed(point_x)) - 35'(hx);
              dsy <= 35'($signed(point_y)) - 35'(hy);
              state <= S_NORM;
              ret <= S_IDLE;
            end
          end
        end
        S_NORM: begin
          ax <= dsx[34] ? 34'(-dsx) : 34'(dsx);
          ay <= dsy[34] ? 34'(-dsy) : 34'(dsy);
          nx <= dsx[34];
          ny <= dsy[34];
          state <= S_SQ;
        end
        S_SQ: begin
          if (m == 34'd0) begin
            ox <= '0;
            oy <= '0;
            state <= S_MQ;
          end else if (m < (34'd1 << 30)) begin
            ax <= ax << 1;
            ay <= ay << 1;
          end else if (m >= (34'd1 << 31)) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else begin
            du_num <= mul;
            du_sqrt <= 1'b1;
            du_start <= 1'b1;
            ret <= S_DX;
            state <= S_WAITD;
          end
        end
        S_WAITD: begin
          if (du_done) begin
            unique case (ret)
              S_DX: begin
                len <= du_res;
                du_num <= {14'd0, ax, 16'd0};
                du_den <= du_res;
                du_sqrt <= 1'b0;
                du_start <= 1'b1;
                ret <= S_DY;
              end
              S_DY: begin
                ox <= nx ? -pme_pkg::dir_t'(du_res) : pme_pkg::dir_t'(du_res);
                du_num <= {14'd0, ay, 16'd0};
                du_den <= len;
                du_start <= 1'b1;
                ret <= S_MQ;
              end
              S_MQ: begin
                oy <= ny ? -pme_pkg::dir_t'(du_res) : pme_pkg::dir_t'(du_res);
                state <= S_MQ;
              end
              S_MX: begin
                dsx <= nx ? -35'(du_res) : 35'(du_res);
                du_num <= {30'd0, ay} << (2 * DIR_FRAC_C + 1);
                du_den <= mq;
                du_start <= 1'b1;
                ret <= S_MY;
              end
              S_MY: begin
                dsy <= ny ? -35'(du_res) : 35'(du_res);
                state <= S_OX;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MQ: begin
          if (seen == 2'd1 || second) begin
            dsx <= 35'(ox);
            dsy <= 35'(oy);
            state <= S_OX;
          end else begin
            ax <= sxs[34] ? 34'(-sxs) : 34'(sxs);
            ay <= sys[34] ? 34'(-sys) : 34'(sys);
            nx <= sxs[34];
            ny <= sys[34];
            dsx <= sxs;
            dsy <= sys;
            state <= S_MX;
          end
        end
        S_MX: begin
          mq <= mul;
          if (mul * 64'(MITER_CLAMP) <= LIM) begin
            dsx <= dsx * 35'(MITER_CLAMP);
            dsy <= dsy * 35'(MITER_CLAMP);
            state <= S_OX;
          end else begin
            du_num <= {30'd0, ax} << (2 * DIR_FRAC_C + 1);
            du_den <= mul;
            du_sqrt <= 1'b0;
            du_start <= 1'b1;
            ret <= S_MX;
            state <= S_WAITD;
          end
        end
        S_OX: begin
          ax <= dsx[34] ? 34'(-dsx) : 34'(dsx);
          ay <= dsy[34] ? 34'(-dsy) : 34'(dsy);
          nx <= dsx[34];
          ny <= dsy[34];
          state <= S_OY;
        end
        S_OY: begin
          offx <= 36'(({30'd0, ax} * {48'd0, rw} + RND) >> SH);
          offy <= 36'(({30'd0, ay} * {48'd0, rw} + RND) >> SH);
          emit_zero <= 1'b0;
          if (second) begin
            ex <= px; ey <= py; elast <= 1'b1;
          end else begin
            ex <= hx; ey <= hy; elast <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            outr.left_x <= pme_pkg::sat32(36'(ex) - 36'(sofy));
            outr.left_y <= pme_pkg::sat32(36'(ey) + 36'(sofx));
            outr.right_x <= pme_pkg::sat32(36'(ex) + 36'(sofy));
            outr.right_y <= pme_pkg::sat32(36'(ey) - 36'(sofx));
            outr.last_pair <= elast;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (elast) begin
            seen <= '0;
            hx <= '0; hy <= '0; ix <= '0; iy <= '0;
            state <= S_IDLE;
          end else if (lastp) begin
            second <= 1'b1;
            state <= S_MQ;
          end else begin
            hx <= px; hy <= py; ix <= ox; iy <= oy;
            seen <= 2'd2;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign left_x = outr.left_x;
  assign left_y = outr.left_y;
  assign right_x = outr.right_x;
  assign right_y = outr.right_y;
  assign last_pair = outr.last_pair;

endmodule
